>>> rtl/trba_pkg.sv
// Package for the tagged reference-counted block allocator.
// Holds the command and status codes, the controller states and the
// parameter defaults. No dependencies.
package trba_pkg;

  // Parameter defaults
  localparam int unsigned NUM_BLOCKS_DEF     = 256;
  localparam int unsigned INITIAL_BLOCKS_DEF = 64;
  localparam int unsigned GROW_STEP_DEF      = 64;
  localparam int unsigned COUNT_BITS_DEF     = 16;

  // Command codes carried by kind_i
  typedef enum logic [2:0] {
    KIND_ALLOCATE = 3'd0,
    KIND_RESERVE  = 3'd1,
    KIND_ATTACH   = 3'd2,
    KIND_SHARE    = 3'd3,
    KIND_RELEASE  = 3'd4,
    KIND_FREE     = 3'd5
  } kind_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_BUSY      = 3'd2,
    STAT_EXHAUSTED = 3'd3,
    STAT_COUNT_ERR = 3'd4
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_GROW
  } state_e;

endpackage

>>> rtl/tagged_refcount_block_allocator.sv
// Top level of the tagged reference-counted block allocator.
// One block record memory with read-modify-write control; uses trba_pkg.
//
// Channel   Direction  Handshake                  Payload
// command   in         start_i high, busy_o low   kind, block_number, tag, block_type, id
// result    out        done_o for one cycle       status, result_number, result_tag,
//                                                 result_count
//
// A command that touches a block record has its memory read issued on the accepting edge;
// the record is modified and written back on the next.
// Range, unused-kind and pool-exhausted errors answer in the cycle after acceptance.
// A pop from an empty list grows the pool, writing one new block per cycle, up to GROW_STEP.
// After reset an initialisation pass writes min(INITIAL_BLOCKS, NUM_BLOCKS) records,
// one per cycle, with busy_o high. The result side cannot stall; each beat is shown
// for exactly one cycle.
module tagged_refcount_block_allocator #(
  parameter int unsigned NUM_BLOCKS     = trba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned INITIAL_BLOCKS = trba_pkg::INITIAL_BLOCKS_DEF,
  parameter int unsigned GROW_STEP      = trba_pkg::GROW_STEP_DEF,
  parameter int unsigned COUNT_BITS     = trba_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  block_number_i,
  input  logic [31:0] tag_i,
  input  logic [7:0]  block_type_i,
  input  logic [63:0] id_high_i,
  input  logic [63:0] id_low_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [7:0]  result_number_o,
  output logic [31:0] result_tag_o,
  output logic [15:0] result_count_o
);

  localparam int unsigned IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned LINK_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned INIT_N = (INITIAL_BLOCKS > NUM_BLOCKS) ? NUM_BLOCKS
                                                                 : INITIAL_BLOCKS;
  localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(NUM_BLOCKS);
  localparam logic [LINK_W-1:0] INIT_LAST  = LINK_W'(INIT_N - 1);
  localparam logic [LINK_W-1:0] INIT_LIMIT = LINK_W'(INIT_N);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  typedef struct packed {
    logic [LINK_W-1:0]     nxt;
    logic [31:0]           gen;
    logic [COUNT_BITS-1:0] cnt;
    logic [7:0]            btype;
    logic [63:0]           owner_hi;
    logic [63:0]           owner_lo;
  } rec_t;

  trba_pkg::state_e state_q, state_d;

  rec_t              mem [NUM_BLOCKS];
  rec_t              rd_q;
  rec_t              wdata;
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;

  logic [LINK_W-1:0] head_q, head_d, limit_q, limit_d, walk_q, walk_d, end_q, end_d;
  logic [IDX_W-1:0]  n_q, n_d;
  logic [2:0]        kind_q;
  logic [31:0]       tag_q;
  logic [7:0]        btype_q;
  logic [63:0]       idh_q, idl_q;

  logic              done_q, done_d;
  logic [2:0]        status_q, status_d;
  logic [7:0]        num_q, num_d;
  logic [31:0]       rtag_q, rtag_d;
  logic [COUNT_BITS-1:0] rcnt_q, rcnt_d;

  logic              accept;
  logic              is_pop, bad_cmd, list_empty, pool_full;
  logic [31:0]       grow_sum;
  logic [LINK_W-1:0] grow_end;
  logic              id_given, id_match;
  logic [COUNT_BITS-1:0] cnt_dec;

  assign accept     = start_i && (state_q == trba_pkg::ST_IDLE);
  assign is_pop     = (kind_i == trba_pkg::KIND_ALLOCATE) ||
                      (kind_i == trba_pkg::KIND_RESERVE);
  assign bad_cmd    = (kind_i > trba_pkg::KIND_FREE) ||
                      ({24'd0, block_number_i} >= 32'(limit_q));
  assign list_empty = (head_q == NULL_LINK);
  assign pool_full  = (limit_q == NULL_LINK);
  assign grow_sum   = 32'(limit_q) + 32'(GROW_STEP);
  assign grow_end   = (grow_sum > 32'(NUM_BLOCKS)) ? NULL_LINK : LINK_W'(grow_sum);
  assign id_given   = (idh_q | idl_q) != 64'd0;
  assign id_match   = (idh_q == rd_q.owner_hi) && (idl_q == rd_q.owner_lo);
  assign cnt_dec    = rd_q.cnt - COUNT_ONE;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trba_pkg::ST_INIT: begin
        if (walk_q == INIT_LAST) state_d = trba_pkg::ST_IDLE;
      end
      trba_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_pop) begin
            if (!list_empty)     state_d = trba_pkg::ST_EXEC;
            else if (!pool_full) state_d = trba_pkg::ST_GROW;
          end else if (!bad_cmd) begin
            state_d = trba_pkg::ST_EXEC;
          end
        end
      end
      trba_pkg::ST_EXEC: state_d = trba_pkg::ST_IDLE;
      trba_pkg::ST_GROW: begin
        if (walk_q == end_q - LINK_W'(1)) state_d = trba_pkg::ST_IDLE;
      end
      default: state_d = trba_pkg::ST_IDLE;
    endcase
  end

  // Datapath: memory accesses, list pointers and result beat
  always_comb begin
    we       = 1'b0;
    waddr    = n_q;
    wdata    = rd_q;
    raddr    = IDX_W'(block_number_i);
    n_d      = n_q;
    head_d   = head_q;
    limit_d  = limit_q;
    walk_d   = walk_q;
    end_d    = end_q;
    done_d   = 1'b0;
    status_d = status_q;
    num_d    = num_q;
    rtag_d   = rtag_q;
    rcnt_d   = rcnt_q;
    unique case (state_q)
      // write the initial chain, one record per cycle
      trba_pkg::ST_INIT: begin
        we             = 1'b1;
        waddr          = walk_q[IDX_W-1:0];
        wdata          = '0;
        wdata.gen      = 32'd1;
        wdata.nxt      = (walk_q == INIT_LAST) ? NULL_LINK : walk_q + LINK_W'(1);
        walk_d         = walk_q + LINK_W'(1);
      end
      // take a beat, issue the record read or answer at once
      trba_pkg::ST_IDLE: begin
        if (is_pop) raddr = head_q[IDX_W-1:0];
        if (accept) begin
          n_d = raddr;
          if (is_pop) begin
            if (list_empty && pool_full) begin
              done_d   = 1'b1;
              status_d = trba_pkg::STAT_EXHAUSTED;
              num_d    = 8'd0;
              rtag_d   = 32'd0;
              rcnt_d   = '0;
            end else if (list_empty) begin
              walk_d = limit_q;
              end_d  = grow_end;
            end
          end else if (bad_cmd) begin
            done_d   = 1'b1;
            status_d = trba_pkg::STAT_NOT_FOUND;
            num_d    = block_number_i;
            rtag_d   = 32'd0;
            rcnt_d   = '0;
          end
        end
      end
      // modify the record read last cycle and write it back
      trba_pkg::ST_EXEC: begin
        done_d   = 1'b1;
        status_d = trba_pkg::STAT_OK;
        num_d    = 8'(n_q);
        rtag_d   = rd_q.gen;
        rcnt_d   = rd_q.cnt;
        priority if (kind_q == trba_pkg::KIND_ALLOCATE ||
                     kind_q == trba_pkg::KIND_RESERVE) begin
          we          = 1'b1;
          wdata.btype = btype_q;
          head_d      = rd_q.nxt;
          if (kind_q == trba_pkg::KIND_ALLOCATE) begin
            wdata.cnt = COUNT_ONE;
          end else begin
            wdata.cnt      = '0;
            wdata.owner_hi = idh_q;
            wdata.owner_lo = idl_q;
          end
          rcnt_d = wdata.cnt;
        end else if (kind_q == trba_pkg::KIND_ATTACH &&
                     (tag_q != rd_q.gen || rd_q.cnt == '0)) begin
          status_d = trba_pkg::STAT_NOT_FOUND;
        end else if (kind_q == trba_pkg::KIND_ATTACH ||
                     kind_q == trba_pkg::KIND_SHARE) begin
          if (rd_q.cnt == COUNT_MAX) begin
            status_d = trba_pkg::STAT_COUNT_ERR;
          end else begin
            we        = 1'b1;
            wdata.cnt = rd_q.cnt + COUNT_ONE;
            rcnt_d    = wdata.cnt;
          end
        end else if (kind_q == trba_pkg::KIND_RELEASE) begin
          if (rd_q.cnt == '0) begin
            status_d = trba_pkg::STAT_COUNT_ERR;
          end else begin
            we        = 1'b1;
            wdata.cnt = cnt_dec;
            rcnt_d    = cnt_dec;
            if (cnt_dec == '0) begin
              wdata.btype = btype_q;
              if (btype_q == 8'd0) begin
                wdata.owner_hi = '0;
                wdata.owner_lo = '0;
                wdata.gen      = rd_q.gen + 32'd1;
                wdata.nxt      = head_q;
                head_d         = LINK_W'(n_q);
                rtag_d         = wdata.gen;
              end
            end
          end
        end else begin
          // free
          if (rd_q.btype == 8'd0 || (id_given && !id_match)) begin
            status_d = trba_pkg::STAT_NOT_FOUND;
          end else if (rd_q.cnt != '0) begin
            status_d = trba_pkg::STAT_BUSY;
          end else begin
            we             = 1'b1;
            wdata.btype    = 8'd0;
            wdata.owner_hi = '0;
            wdata.owner_lo = '0;
            wdata.gen      = rd_q.gen + 32'd1;
            wdata.nxt      = head_q;
            head_d         = LINK_W'(n_q);
            rtag_d         = wdata.gen;
          end
        end
      end
      // push fresh blocks in ascending order, then allocate the last one
      trba_pkg::ST_GROW: begin
        we        = 1'b1;
        waddr     = walk_q[IDX_W-1:0];
        wdata     = '0;
        wdata.gen = 32'd1;
        wdata.nxt = (walk_q == limit_q) ? NULL_LINK : walk_q - LINK_W'(1);
        walk_d    = walk_q + LINK_W'(1);
        if (walk_q == end_q - LINK_W'(1)) begin
          wdata.nxt   = NULL_LINK;
          wdata.btype = btype_q;
          if (kind_q == trba_pkg::KIND_ALLOCATE) begin
            wdata.cnt = COUNT_ONE;
          end else begin
            wdata.owner_hi = idh_q;
            wdata.owner_lo = idl_q;
          end
          head_d   = (walk_q == limit_q) ? NULL_LINK : walk_q - LINK_W'(1);
          limit_d  = end_q;
          done_d   = 1'b1;
          status_d = trba_pkg::STAT_OK;
          num_d    = 8'(walk_q);
          rtag_d   = 32'd1;
          rcnt_d   = wdata.cnt;
        end
      end
      default: ;
    endcase
  end

  // Block record memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trba_pkg::ST_INIT;
      head_q  <= '0;
      limit_q <= INIT_LIMIT;
      walk_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      limit_q <= limit_d;
      walk_q  <= walk_d;
      done_q  <= done_d;
    end
  end

  // Hold the command beat and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      tag_q   <= tag_i;
      btype_q <= block_type_i;
      idh_q   <= id_high_i;
      idl_q   <= id_low_i;
    end
    n_q      <= n_d;
    end_q    <= end_d;
    status_q <= status_d;
    num_q    <= num_d;
    rtag_q   <= rtag_d;
    rcnt_q   <= rcnt_d;
  end

  assign busy_o          = (state_q != trba_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign result_number_o = num_q;
  assign result_tag_o    = rtag_q;
  assign result_count_o  = 16'(rcnt_q);

  // The pool never shrinks
  a_limit_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (limit_q >= $past(limit_q)))
    else $error("block limit decreased");

  // The free list head is a block index or the null link, and the pool limit does not exceed the null link
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= NULL_LINK) && (limit_q <= NULL_LINK))
    else $error("free list head or limit out of range");

  // A record update answers on the cycle after it
  a_exec_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == trba_pkg::ST_EXEC) |=> (done_o && !busy_o))
    else $error("record update gave no result beat");

  // No result beat during the initialisation pass
  a_no_done_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == trba_pkg::ST_INIT) |-> !done_o)
    else $error("result beat during initialisation");

endmodule

>>> dv/tagged_refcount_block_allocator_tb.sv
// Self-checking testbench for the tagged reference-counted block allocator.
// Drives commands from a directed table and then at random, and predicts each result.
// Depends on trba_pkg and the tagged_refcount_block_allocator RTL.
module tagged_refcount_block_allocator_tb;

  localparam int unsigned NBLK     = trba_pkg::NUM_BLOCKS_DEF;
  localparam int unsigned INIT_BLK = trba_pkg::INITIAL_BLOCKS_DEF;
  localparam int unsigned GROW     = trba_pkg::GROW_STEP_DEF;
  localparam int unsigned CNT_MAX  = (1 << trba_pkg::COUNT_BITS_DEF) - 1;
  localparam int unsigned NULL_IDX = NBLK;
  localparam logic [2:0]  KIND_UNUSED = 3'd6;
  localparam int          DONT_CARE = -1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  num;
    logic [31:0] tag;
    logic [7:0]  btype;
    logic [63:0] idh;
    logic [63:0] idl;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  num;
    logic [31:0] tag;
    logic [15:0] count;
  } res_t;

  typedef struct {
    cmd_t cmd;
    int   want_status;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  kind_i = '0;
  logic [7:0]  block_number_i = '0;
  logic [31:0] tag_i = '0;
  logic [7:0]  block_type_i = '0;
  logic [63:0] id_high_i = '0;
  logic [63:0] id_low_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [7:0]  result_number_o;
  logic [31:0] result_tag_o;
  logic [15:0] result_count_o;

  tagged_refcount_block_allocator DUT (.*);

  always #1 clk_i = ~clk_i;

  // Shadow copy of the block records
  int unsigned     sh_head, sh_limit;
  int unsigned     sh_next [NBLK];
  logic [31:0]     sh_gen  [NBLK];
  int unsigned     sh_cnt  [NBLK];
  logic [7:0]      sh_type [NBLK];
  logic [63:0]     sh_oh   [NBLK];
  logic [63:0]     sh_ol   [NBLK];

  res_t        pending_q [$];
  int          want_q [$];
  int unsigned n_fail = 0, n_beats = 0, n_cmds = 0;
  int unsigned n_stat [8];

  function automatic void free_push(int unsigned n);
    sh_gen[n]  = sh_gen[n] + 32'd1;
    sh_next[n] = sh_head;
    sh_head    = n;
  endfunction

  function automatic void records_reset();
    sh_head = NULL_IDX;
    sh_limit = INIT_BLK;
    for (int i = 0; i < NBLK; i++) begin
      sh_next[i] = NULL_IDX; sh_gen[i] = '0; sh_cnt[i] = 0;
      sh_type[i] = '0; sh_oh[i] = '0; sh_ol[i] = '0;
    end
    for (int i = INIT_BLK; i > 0; i--) free_push(i - 1);
  endfunction

  function automatic res_t predict_outcome(cmd_t c);
    res_t        r;
    int unsigned n, e;
    r = '0;
    if (c.kind == trba_pkg::KIND_ALLOCATE || c.kind == trba_pkg::KIND_RESERVE) begin
      // grow on an empty list
      if (sh_head == NULL_IDX && sh_limit < NBLK) begin
        e = sh_limit + GROW;
        if (e > NBLK) e = NBLK;
        for (int i = sh_limit; i < e; i++) free_push(i);
        sh_limit = e;
      end
      if (sh_head == NULL_IDX) begin
        r.status = trba_pkg::STAT_EXHAUSTED;
        return r;
      end
      n = sh_head;
      sh_head = sh_next[n];
      sh_type[n] = c.btype;
      if (c.kind == trba_pkg::KIND_ALLOCATE) sh_cnt[n] = 1;
      else begin
        sh_cnt[n] = 0; sh_oh[n] = c.idh; sh_ol[n] = c.idl;
      end
      r.status = trba_pkg::STAT_OK; r.num = 8'(n); r.tag = sh_gen[n];
      r.count = 16'(sh_cnt[n]);
      return r;
    end
    r.num = c.num;
    if (c.kind > trba_pkg::KIND_FREE || c.num >= sh_limit) begin
      r.status = trba_pkg::STAT_NOT_FOUND;
      return r;
    end
    n = c.num;
    r.tag = sh_gen[n];
    r.count = 16'(sh_cnt[n]);
    case (c.kind)
      trba_pkg::KIND_ATTACH, trba_pkg::KIND_SHARE: begin
        if (c.kind == trba_pkg::KIND_ATTACH && (c.tag != sh_gen[n] || sh_cnt[n] == 0)) begin
          r.status = trba_pkg::STAT_NOT_FOUND;
          return r;
        end
        if (sh_cnt[n] >= CNT_MAX) begin
          r.status = trba_pkg::STAT_COUNT_ERR;
          return r;
        end
        sh_cnt[n]++;
      end
      trba_pkg::KIND_RELEASE: begin
        if (sh_cnt[n] == 0) begin
          r.status = trba_pkg::STAT_COUNT_ERR;
          return r;
        end
        sh_cnt[n]--;
        if (sh_cnt[n] == 0) begin
          sh_type[n] = c.btype;
          if (c.btype == 8'd0) begin
            sh_oh[n] = '0; sh_ol[n] = '0;
            free_push(n);
          end
        end
      end
      default: begin
        if (sh_type[n] == 8'd0 || ((c.idh | c.idl) != 64'd0 &&
            (c.idh != sh_oh[n] || c.idl != sh_ol[n]))) begin
          r.status = trba_pkg::STAT_NOT_FOUND;
          return r;
        end
        if (sh_cnt[n] != 0) begin
          r.status = trba_pkg::STAT_BUSY;
          return r;
        end
        sh_type[n] = '0; sh_oh[n] = '0; sh_ol[n] = '0;
        free_push(n);
      end
    endcase
    r.status = trba_pkg::STAT_OK; r.tag = sh_gen[n]; r.count = 16'(sh_cnt[n]);
    return r;
  endfunction

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    res_t exp_r, got;
    int   want;
    if (rst_ni && done_o) begin
      got = {status_o, result_number_o, result_tag_o, result_count_o};
      n_beats++;
      if (pending_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("ERROR: unexpected result beat %p", got);
      end else begin
        exp_r = pending_q.pop_front();
        want = want_q.pop_front();
        n_stat[got.status]++;
        if (got !== exp_r || (want != DONT_CARE && int'(got.status) != want)) begin
          n_fail++;
          if (n_fail <= 10)
            $display("ERROR: beat %0d status %0d/%0d num %0d/%0d tag %h/%h count %0d/%0d",
                     n_beats, exp_r.status, got.status, exp_r.num, got.num,
                     exp_r.tag, got.tag, exp_r.count, got.count);
        end
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Present one command and hold it until it is taken
  task automatic send_cmd(cmd_t c, int want);
    int unsigned g;
    g = gap_len();
    @(negedge clk_i);
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    start_i <= 1'b1;
    {kind_i, block_number_i, tag_i, block_type_i, id_high_i, id_low_i} <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_q.push_back(predict_outcome(c));
    want_q.push_back(want);
    n_cmds++;
  endtask

  function automatic cmd_t mk(logic [2:0] k, logic [7:0] n, logic [31:0] t,
                              logic [7:0] b, logic [63:0] h, logic [63:0] l);
    cmd_t c;
    c = {k, n, t, b, h, l};
    return c;
  endfunction

  // Directed sequence: every command, the edges and the not-found, busy and count-error paths
  row_t directed [] = '{
    '{mk(trba_pkg::KIND_ALLOCATE, 0, 0, 8'h01, 0, 0), trba_pkg::STAT_OK},
    '{mk(trba_pkg::KIND_RESERVE, 0, 0, 8'hFF, '1, '1), trba_pkg::STAT_OK},
    '{mk(trba_pkg::KIND_ATTACH, 0, 32'd1, 0, 0, 0), trba_pkg::STAT_OK},
    '{mk(trba_pkg::KIND_ATTACH, 0, 32'd7, 0, 0, 0), trba_pkg::STAT_NOT_FOUND},
    '{mk(trba_pkg::KIND_ATTACH, 1, 32'd1, 0, 0, 0), trba_pkg::STAT_NOT_FOUND},
    '{mk(trba_pkg::KIND_SHARE, 1, 0, 0, 0, 0), trba_pkg::STAT_OK},
    '{mk(trba_pkg::KIND_RELEASE, 1, 0, 8'h05, 0, 0), trba_pkg::STAT_OK},
    '{mk(trba_pkg::KIND_RELEASE, 1, 0, 0, 0, 0), trba_pkg::STAT_COUNT_ERR},
    '{mk(trba_pkg::KIND_FREE, 0, 0, 0, 0, 0), trba_pkg::STAT_BUSY},
    '{mk(trba_pkg::KIND_FREE, 1, 0, 0, 64'h1, 0), trba_pkg::STAT_NOT_FOUND},
    '{mk(trba_pkg::KIND_FREE, 1, 0, 0, 0, 0), trba_pkg::STAT_OK},
    '{mk(trba_pkg::KIND_FREE, 1, 0, 0, 0, 0), trba_pkg::STAT_NOT_FOUND},
    '{mk(trba_pkg::KIND_FREE, 2, 0, 0, 0, 0), trba_pkg::STAT_NOT_FOUND},
    '{mk(trba_pkg::KIND_RELEASE, 0, 0, 0, 0, 0), trba_pkg::STAT_OK},
    '{mk(trba_pkg::KIND_RELEASE, 0, 0, 0, 0, 0), trba_pkg::STAT_OK},
    '{mk(trba_pkg::KIND_SHARE, 8'd255, '1, 0, 0, 0), trba_pkg::STAT_NOT_FOUND},
    '{mk(trba_pkg::KIND_RELEASE, 8'd64, 0, 0, 0, 0), trba_pkg::STAT_NOT_FOUND},
    '{mk(KIND_UNUSED, 8'd3, 0, 0, 0, 0), trba_pkg::STAT_NOT_FOUND},
    '{mk(3'd7, 8'hAA, '1, '1, '1, '1), trba_pkg::STAT_NOT_FOUND},
    '{mk(trba_pkg::KIND_RESERVE, 0, 0, 8'h80, 64'h8000_0000_0000_0001, 64'h1),
      DONT_CARE},
    '{mk(trba_pkg::KIND_FREE, 1, 0, 0, 64'h8000_0000_0000_0001, 64'h1), DONT_CARE}
  };

  // Random command biased towards blocks inside the pool limit so that counts build up
  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned p, n;
    c = {3'd0, 8'($urandom), $urandom, 8'($urandom),
         {$urandom, $urandom}, {$urandom, $urandom}};
    p = $urandom_range(0, 99);
    if (p < 22) c.kind = trba_pkg::KIND_ALLOCATE;
    else if (p < 32) c.kind = trba_pkg::KIND_RESERVE;
    else if (p < 47) c.kind = trba_pkg::KIND_ATTACH;
    else if (p < 60) c.kind = trba_pkg::KIND_SHARE;
    else if (p < 82) c.kind = trba_pkg::KIND_RELEASE;
    else if (p < 97) c.kind = trba_pkg::KIND_FREE;
    else c.kind = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 9) < 8) begin
      n = $urandom_range(0, sh_limit - 1);
      c.num = 8'(n);
      if ($urandom_range(0, 3) != 0) c.tag = sh_gen[n];
      if ($urandom_range(0, 2) != 0) begin
        c.idh = sh_oh[n]; c.idl = sh_ol[n];
      end else if ($urandom_range(0, 2) == 0) begin
        c.idh = '0; c.idl = '0;
      end
    end
    // Mostly free on final release, to keep the pool cycling
    if (c.kind == trba_pkg::KIND_RELEASE && $urandom_range(0, 3) != 0) c.btype = '0;
    if ((c.kind == trba_pkg::KIND_ALLOCATE || c.kind == trba_pkg::KIND_RESERVE) &&
        c.btype == 8'd0)
      c.btype = 8'd1;
    return c;
  endfunction

  initial begin
    records_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send_cmd(directed[i].cmd, directed[i].want_status);
    for (int i = 0; i < 700; i++) send_cmd(rand_cmd(), DONT_CARE);
    @(negedge clk_i);
    start_i <= 1'b0;
    fork
      begin
        wait (pending_q.size() == 0);
        repeat (80) @(posedge clk_i);
      end
      begin
        repeat (20000) @(posedge clk_i);
        n_fail++;
      end
    join_any
    if (pending_q.size() != 0) n_fail++;
    $display("Commands sent: %0d, results checked: %0d, pool limit reached %0d",
             n_cmds, n_beats, sh_limit);
    $display("Status mix ok %0d not-found %0d busy %0d exhausted %0d count-err %0d",
             n_stat[0], n_stat[1], n_stat[2], n_stat[3], n_stat[4]);
    if (n_fail == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> filelist.f
rtl/trba_pkg.sv
rtl/tagged_refcount_block_allocator.sv
dv/tagged_refcount_block_allocator_tb.sv
